### src/gvj_pkg.sv
// Package for the grid vector Jacobian core: request and result payloads,
// register indexes, fixed field widths and the controller-to-datapath command word.
// No dependencies.
`timescale 1ns / 1ps

package gvj_pkg;

  // Fixed field widths.
  localparam int COORD_XY_W = 6;
  localparam int COORD_Z_W  = 4;
  localparam int COMP_W     = 16;
  localparam int RES_W      = 32;
  localparam int SIZE_W     = 7;
  localparam int SIZE_Z_W   = 5;
  localparam int INV_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Inverse spacings are Q16.16; a central difference takes one more bit of shift.
  localparam int FRAC_SHIFT = 16;

  // Default grid limits and sample width.
  localparam int MAX_SIZE_X_DEF   = 64;
  localparam int MAX_SIZE_Y_DEF   = 64;
  localparam int MAX_SIZE_Z_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Register reset values.
  localparam logic [SIZE_W-1:0]   SIZE_X_RST = 7'd64;
  localparam logic [SIZE_W-1:0]   SIZE_Y_RST = 7'd64;
  localparam logic [SIZE_Z_W-1:0] SIZE_Z_RST = 5'd16;
  localparam logic [INV_W-1:0]    INV_RST    = 32'd65536;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z  = 3'd5;

  // Request kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Saturation limits of a result.
  localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // One request: a sample write or a derivative query.
  typedef struct packed {
    logic                      kind;
    logic [COORD_XY_W-1:0]     pos_x;
    logic [COORD_XY_W-1:0]     pos_y;
    logic [COORD_Z_W-1:0]      pos_z;
    logic signed [COMP_W-1:0]  comp_x;
    logic signed [COMP_W-1:0]  comp_y;
    logic signed [COMP_W-1:0]  comp_z;
  } gvj_req_t;

  // One result: nine partial derivatives and the range flag.
  typedef struct packed {
    logic signed [RES_W-1:0] dx_of_vx;
    logic signed [RES_W-1:0] dx_of_vy;
    logic signed [RES_W-1:0] dx_of_vz;
    logic signed [RES_W-1:0] dy_of_vx;
    logic signed [RES_W-1:0] dy_of_vy;
    logic signed [RES_W-1:0] dy_of_vz;
    logic signed [RES_W-1:0] dz_of_vx;
    logic signed [RES_W-1:0] dz_of_vy;
    logic signed [RES_W-1:0] dz_of_vz;
    logic                    out_of_range;
  } gvj_rsp_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic  wr_en;     // store the accepted write request
    logic  load;      // latch the accepted query request
    logic  rd_en;     // read one grid word
    logic  rd_hi;     // read the upper neighbor instead of the lower one
    axis_e rd_axis;
    logic  lo_en;     // keep the word just read as the lower neighbor
    logic  diff_en;   // form the three differences
    logic  mul_en;    // scale the differences by the inverse spacing
    axis_e mul_axis;
    logic  rnd_en;    // round, saturate and store one row of results
    axis_e rnd_axis;
  } gvj_cmd_t;

endpackage

### src/gvj_ctrl.sv
// Sequencer of the grid vector Jacobian core: accepts requests and steps a query
// through six grid reads and the difference, scale and round stages.
// Depends on gvj_pkg.
`timescale 1ns / 1ps

module gvj_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  output logic              busy_o,
  output logic              done_o,
  output gvj_pkg::gvj_cmd_t cmd_o
);
  import gvj_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_X_LO,
    ST_RD_X_HI,
    ST_RD_Y_LO,
    ST_RD_Y_HI,
    ST_RD_Z_LO,
    ST_RD_Z_HI,
    ST_DIFF_Z,
    ST_MUL_Z,
    ST_RND_Z
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic       done_q, done_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  // Command decode and next state; reads and arithmetic stages overlap by axis.
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_en   = accept && (kind_i == KIND_WRITE);
    cmd_o.load    = accept && (kind_i == KIND_QUERY);
    state_d       = state_q;
    done_d        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_RD_X_LO;
      end
      ST_RD_X_LO: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_axis = AXIS_X;
        state_d       = ST_RD_X_HI;
      end
      ST_RD_X_HI: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_hi   = 1'b1;
        cmd_o.rd_axis = AXIS_X;
        cmd_o.lo_en   = 1'b1;
        state_d       = ST_RD_Y_LO;
      end
      ST_RD_Y_LO: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_axis = AXIS_Y;
        cmd_o.diff_en = 1'b1;
        state_d       = ST_RD_Y_HI;
      end
      ST_RD_Y_HI: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_hi    = 1'b1;
        cmd_o.rd_axis  = AXIS_Y;
        cmd_o.lo_en    = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = AXIS_X;
        state_d        = ST_RD_Z_LO;
      end
      ST_RD_Z_LO: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_axis  = AXIS_Z;
        cmd_o.diff_en  = 1'b1;
        cmd_o.rnd_en   = 1'b1;
        cmd_o.rnd_axis = AXIS_X;
        state_d        = ST_RD_Z_HI;
      end
      ST_RD_Z_HI: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_hi    = 1'b1;
        cmd_o.rd_axis  = AXIS_Z;
        cmd_o.lo_en    = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = AXIS_Y;
        state_d        = ST_DIFF_Z;
      end
      ST_DIFF_Z: begin
        cmd_o.diff_en  = 1'b1;
        cmd_o.rnd_en   = 1'b1;
        cmd_o.rnd_axis = AXIS_Y;
        state_d        = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = AXIS_Z;
        state_d        = ST_RND_Z;
      end
      ST_RND_Z: begin
        cmd_o.rnd_en   = 1'b1;
        cmd_o.rnd_axis = AXIS_Z;
        state_d        = ST_IDLE;
        done_d         = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

`ifndef SYNTHESIS
  // The result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // The sequencer only returns to idle while presenting a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy_o) |-> done_o)
    else $error("query ended without a result");

  // An accepted query occupies the sequencer and ends with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o && (kind_i == KIND_QUERY)) |=> busy_o ##9 done_o)
    else $error("query result not delivered on schedule");

  // A write request never occupies the sequencer or produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o && (kind_i == KIND_WRITE)) |=> (!busy_o && !done_o))
    else $error("write request started a query");
`endif

endmodule

### src/gvj_datapath.sv
// Datapath of the grid vector Jacobian core: configuration registers, the sample
// grid memory, neighbor addressing, and the difference, scale and round stages.
// Depends on gvj_pkg.
`timescale 1ns / 1ps

module gvj_datapath #(
  parameter int MAX_SIZE_X   = gvj_pkg::MAX_SIZE_X_DEF,
  parameter int MAX_SIZE_Y   = gvj_pkg::MAX_SIZE_Y_DEF,
  parameter int MAX_SIZE_Z   = gvj_pkg::MAX_SIZE_Z_DEF,
  parameter int SAMPLE_WIDTH = gvj_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gvj_pkg::gvj_req_t                 req_i,
  input  logic                              cfg_we_i,
  input  logic [gvj_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gvj_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  gvj_pkg::gvj_cmd_t                 cmd_i,
  output gvj_pkg::gvj_rsp_t                 rsp_o
);
  import gvj_pkg::*;

  localparam int Depth = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
  localparam int AddrW = $clog2(Depth);
  localparam int WordW = 3 * SAMPLE_WIDTH;
  localparam int MagW  = SAMPLE_WIDTH + 1;
  localparam int ProdW = MagW + INV_W;
  localparam int SumW  = ProdW + 1;

  // Neighbor pair of one axis around the query point.
  typedef struct packed {
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    logic              cent;
    logic              flat;
  } nbr_t;

  function automatic nbr_t nbr_of(input logic [SIZE_W-1:0] idx,
                                  input logic [SIZE_W-1:0] n);
    nbr_t r;
    r.lo   = idx;
    r.hi   = idx;
    r.cent = 1'b0;
    r.flat = (n <= SIZE_W'(1));
    if (idx == '0) begin
      r.hi = SIZE_W'(1);
    end else if (idx == n - SIZE_W'(1)) begin
      r.lo = idx - SIZE_W'(1);
    end else begin
      r.lo   = idx - SIZE_W'(1);
      r.hi   = idx + SIZE_W'(1);
      r.cent = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [SIZE_W-1:0] x,
                                               input logic [SIZE_W-1:0] y,
                                               input logic [SIZE_W-1:0] z);
    return AddrW'(x) + AddrW'(MAX_SIZE_X) * (AddrW'(y) + AddrW'(MAX_SIZE_Y) * AddrW'(z));
  endfunction

  logic [SIZE_W-1:0]     size_x_q, size_y_q;
  logic [SIZE_Z_W-1:0]   size_z_q;
  logic [INV_W-1:0]      inv_x_q, inv_y_q, inv_z_q;
  logic [SIZE_W-1:0]     eff_x, eff_y, eff_z;

  logic [COORD_XY_W-1:0] pos_x_q, pos_y_q;
  logic [COORD_Z_W-1:0]  pos_z_q;
  logic                  oor_q;
  logic                  oor_d;
  nbr_t                  nbr_x, nbr_y, nbr_z;

  logic [WordW-1:0]      store_q [Depth];
  logic [WordW-1:0]      rd_data_q, lo_word_q, wr_word;
  logic [AddrW-1:0]      wr_addr, rd_addr;
  logic                  wr_ok;
  logic [SIZE_W-1:0]     rd_x, rd_y, rd_z;

  logic signed [MagW-1:0] diff [3];
  logic [MagW-1:0]       mag_d [3];
  logic [MagW-1:0]       mag_q [3];
  logic                  neg_q [3];
  logic                  neg_p_q [3];
  logic [INV_W-1:0]      inv_sel;
  logic [ProdW-1:0]      prod_q [3];

  logic                  rnd_cent, rnd_flat, rnd_zero;
  logic [SumW-1:0]       sum [3];
  logic [SumW-1:0]       quo [3];
  logic [RES_W-1:0]      sat [3];
  logic signed [RES_W-1:0] res_x_q [3];
  logic signed [RES_W-1:0] res_y_q [3];
  logic signed [RES_W-1:0] res_z_q [3];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_X_RST;
      size_y_q <= SIZE_Y_RST;
      size_z_q <= SIZE_Z_RST;
      inv_x_q  <= INV_RST;
      inv_y_q  <= INV_RST;
      inv_z_q  <= INV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Y: size_y_q <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Z: size_z_q <= cfg_data_i[SIZE_Z_W-1:0];
        CFG_INV_X:  inv_x_q  <= cfg_data_i[INV_W-1:0];
        CFG_INV_Y:  inv_y_q  <= cfg_data_i[INV_W-1:0];
        CFG_INV_Z:  inv_z_q  <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes saturate at the grid limits.
  assign eff_x = (int'(size_x_q) > MAX_SIZE_X) ? SIZE_W'(MAX_SIZE_X) : size_x_q;
  assign eff_y = (int'(size_y_q) > MAX_SIZE_Y) ? SIZE_W'(MAX_SIZE_Y) : size_y_q;
  assign eff_z = (int'(size_z_q) > MAX_SIZE_Z) ? SIZE_W'(MAX_SIZE_Z) : SIZE_W'(size_z_q);

  // Query point latch and range check.
  assign oor_d = (SIZE_W'(req_i.pos_x) >= eff_x) || (SIZE_W'(req_i.pos_y) >= eff_y) ||
                 (SIZE_W'(req_i.pos_z) >= eff_z);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= req_i.pos_x;
      pos_y_q <= req_i.pos_y;
      pos_z_q <= req_i.pos_z;
      oor_q   <= oor_d;
    end
  end

  assign nbr_x = nbr_of(SIZE_W'(pos_x_q), eff_x);
  assign nbr_y = nbr_of(SIZE_W'(pos_y_q), eff_y);
  assign nbr_z = nbr_of(SIZE_W'(pos_z_q), eff_z);

  // Write address and word; samples are sign-extended or wrapped to the stored width.
  assign wr_ok   = (int'(req_i.pos_x) < MAX_SIZE_X) && (int'(req_i.pos_y) < MAX_SIZE_Y) &&
                   (int'(req_i.pos_z) < MAX_SIZE_Z);
  assign wr_addr = addr_of(SIZE_W'(req_i.pos_x), SIZE_W'(req_i.pos_y),
                           SIZE_W'(req_i.pos_z));
  assign wr_word = {SAMPLE_WIDTH'(req_i.comp_z), SAMPLE_WIDTH'(req_i.comp_y),
                    SAMPLE_WIDTH'(req_i.comp_x)};

  // Read coordinates: the query point with one axis moved to a neighbor.
  always_comb begin
    rd_x = SIZE_W'(pos_x_q);
    rd_y = SIZE_W'(pos_y_q);
    rd_z = SIZE_W'(pos_z_q);
    unique case (cmd_i.rd_axis)
      AXIS_X:  rd_x = cmd_i.rd_hi ? nbr_x.hi : nbr_x.lo;
      AXIS_Y:  rd_y = cmd_i.rd_hi ? nbr_y.hi : nbr_y.lo;
      AXIS_Z:  rd_z = cmd_i.rd_hi ? nbr_z.hi : nbr_z.lo;
      default: ;
    endcase
  end

  assign rd_addr = addr_of(rd_x, rd_y, rd_z);

  // Single-port sample memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      store_q[wr_addr] <= wr_word;
    end else if (cmd_i.rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  // Hold the lower neighbor until the upper one arrives.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lo_en) lo_word_q <= rd_data_q;
  end

  // Difference stage: sign and magnitude of upper minus lower.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]  = MagW'($signed(rd_data_q[c*SAMPLE_WIDTH +: SAMPLE_WIDTH])) -
                 MagW'($signed(lo_word_q[c*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
      mag_d[c] = diff[c][MagW-1] ? MagW'(-diff[c]) : MagW'(diff[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      for (int c = 0; c < 3; c++) begin
        mag_q[c] <= mag_d[c];
        neg_q[c] <= diff[c][MagW-1];
      end
    end
  end

  // Scale stage: one multiplier per component.
  always_comb begin
    unique case (cmd_i.mul_axis)
      AXIS_X:  inv_sel = inv_x_q;
      AXIS_Y:  inv_sel = inv_y_q;
      AXIS_Z:  inv_sel = inv_z_q;
      default: inv_sel = inv_x_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c]  <= ProdW'(mag_q[c]) * ProdW'(inv_sel);
        neg_p_q[c] <= neg_q[c];
      end
    end
  end

  // Round stage: half away from zero, restore the sign, saturate to 32 bits.
  always_comb begin
    unique case (cmd_i.rnd_axis)
      AXIS_X: begin
        rnd_cent = nbr_x.cent;
        rnd_flat = nbr_x.flat;
      end
      AXIS_Y: begin
        rnd_cent = nbr_y.cent;
        rnd_flat = nbr_y.flat;
      end
      AXIS_Z: begin
        rnd_cent = nbr_z.cent;
        rnd_flat = nbr_z.flat;
      end
      default: begin
        rnd_cent = nbr_x.cent;
        rnd_flat = nbr_x.flat;
      end
    endcase
    rnd_zero = oor_q || rnd_flat;
    for (int c = 0; c < 3; c++) begin
      sum[c] = SumW'(prod_q[c]) + (rnd_cent ? (SumW'(1) << FRAC_SHIFT)
                                            : (SumW'(1) << (FRAC_SHIFT - 1)));
      quo[c] = rnd_cent ? (sum[c] >> (FRAC_SHIFT + 1)) : (sum[c] >> FRAC_SHIFT);
      if (neg_p_q[c]) begin
        sat[c] = (|quo[c][SumW-1:RES_W-1]) ? SAT_NEG : RES_W'(-quo[c][RES_W-1:0]);
      end else begin
        sat[c] = (|quo[c][SumW-1:RES_W-1]) ? SAT_POS : quo[c][RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_en) begin
      for (int c = 0; c < 3; c++) begin
        unique case (cmd_i.rnd_axis)
          AXIS_X:  res_x_q[c] <= rnd_zero ? '0 : sat[c];
          AXIS_Y:  res_y_q[c] <= rnd_zero ? '0 : sat[c];
          AXIS_Z:  res_z_q[c] <= rnd_zero ? '0 : sat[c];
          default: ;
        endcase
      end
    end
  end

  // Result payload.
  assign rsp_o.dx_of_vx     = res_x_q[0];
  assign rsp_o.dx_of_vy     = res_x_q[1];
  assign rsp_o.dx_of_vz     = res_x_q[2];
  assign rsp_o.dy_of_vx     = res_y_q[0];
  assign rsp_o.dy_of_vy     = res_y_q[1];
  assign rsp_o.dy_of_vz     = res_y_q[2];
  assign rsp_o.dz_of_vx     = res_z_q[0];
  assign rsp_o.dz_of_vy     = res_z_q[1];
  assign rsp_o.dz_of_vz     = res_z_q[2];
  assign rsp_o.out_of_range = oor_q;

endmodule

### src/grid_vector_jacobian_core.sv
// Top level of the grid vector Jacobian core; depends on gvj_pkg, gvj_ctrl, gvj_datapath.
// A write request is stored at its accept edge; busy stays low.
// A query holds busy high until its result strobe, and the next request is taken at the
// edge that ends that strobe cycle. No new query is taken while one is in flight; a query
// runs six reads of the single-port grid memory, then three stages: difference, scale, round.
// Reset loads the register defaults and idles the sequencer; grid memory is not cleared.
`timescale 1ns / 1ps

module grid_vector_jacobian_core #(
  parameter int MAX_SIZE_X   = gvj_pkg::MAX_SIZE_X_DEF,
  parameter int MAX_SIZE_Y   = gvj_pkg::MAX_SIZE_Y_DEF,
  parameter int MAX_SIZE_Z   = gvj_pkg::MAX_SIZE_Z_DEF,
  parameter int SAMPLE_WIDTH = gvj_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  gvj_pkg::gvj_req_t              req_i,
  output logic                           done_o,
  output gvj_pkg::gvj_rsp_t              rsp_o,
  input  logic                           cfg_we_i,
  input  logic [gvj_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gvj_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gvj_pkg::*;

  gvj_cmd_t cmd;

  // Request sequencer.
  gvj_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (req_i.kind),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Grid storage and arithmetic.
  gvj_datapath #(
    .MAX_SIZE_X   (MAX_SIZE_X),
    .MAX_SIZE_Y   (MAX_SIZE_Y),
    .MAX_SIZE_Z   (MAX_SIZE_Z),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .rsp_o      (rsp_o)
  );

endmodule
